// ===== rtl/cna_pkg.sv =====
// shared types, codes and helpers of the complex arithmetic unit
package cna_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;
    localparam int unsigned DIV_STAGES      = 32;

    // operation codes
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_NEG = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_OVF = 2'd1;
    localparam logic [1:0] ST_DZ  = 2'd2;

    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        KIND_LIN,
        KIND_MUL,
        KIND_DIV,
        KIND_NONE
    } kind_t;

    // classified item as it sits in the queue
    typedef struct packed {
        kind_t       kind;
        logic        sub;
        logic [31:0] ar;
        logic [31:0] ai;
        logic [31:0] br;
        logic [31:0] bi;
    } cna_item_t;

    // one part of the divider: partial remainder and dividend/quotient shifter
    typedef struct packed {
        logic [63:0] rem;
        logic [31:0] qs;
    } div_part_t;

    // control carried along the divider stages
    typedef struct packed {
        kind_t       kind;
        logic [63:0] d;
        logic        neg_re;
        logic        neg_im;
        logic        ovf_re;
        logic        ovf_im;
        logic [31:0] rr;
        logic [31:0] ri;
        logic [1:0]  st;
    } div_ctl_t;

    // saturate sign plus magnitude to q16.16, msb of result is overflow
    function automatic logic [32:0] sat32(input logic neg, input logic [63:0] mag);
        logic [32:0] r;
        if (!neg) begin
            if (mag > {32'd0, Q_MAX}) r = {1'b1, Q_MAX};
            else                       r = {1'b0, mag[31:0]};
        end
        else begin
            if (mag > {32'd0, Q_MIN}) r = {1'b1, Q_MIN};
            else                       r = {1'b0, (~mag[31:0]) + 32'd1};
        end
        return r;
    endfunction

    // one restoring division step
    function automatic div_part_t div_step(input div_part_t p, input logic [63:0] d);
        div_part_t   n;
        logic [64:0] r2;
        logic [64:0] diff;
        r2   = {p.rem, p.qs[31]};
        diff = r2 - {1'b0, d};
        if (r2 >= {1'b0, d}) begin
            n.rem = diff[63:0];
            n.qs  = {p.qs[30:0], 1'b1};
        end
        else begin
            n.rem = r2[63:0];
            n.qs  = {p.qs[30:0], 1'b0};
        end
        return n;
    endfunction

endpackage

// ===== rtl/cna_in_if.sv =====
// operand channel of the complex arithmetic unit
interface cna_in_if;
    logic              valid;
    logic              ready;
    logic [2:0]        operation;
    logic signed [31:0] a_real;
    logic signed [31:0] a_imag;
    logic signed [31:0] b_real;
    logic signed [31:0] b_imag;

    modport source (output valid, operation, a_real, a_imag, b_real, b_imag, input ready);
    modport sink   (input valid, operation, a_real, a_imag, b_real, b_imag, output ready);
endinterface

// ===== rtl/cna_out_if.sv =====
// result channel of the complex arithmetic unit
interface cna_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_real;
    logic signed [31:0] result_imag;
    logic [1:0]         status;

    modport source (output valid, result_real, result_imag, status, input ready);
    modport sink   (input valid, result_real, result_imag, status, output ready);
endinterface

// ===== rtl/cna_front.sv =====
// front end: takes operand transfers and classifies them for the queue
module cna_front
    import cna_pkg::*;
(
    cna_in_if.sink    operand,
    input  logic      queue_full,
    output logic      push_valid,
    output cna_item_t push_item
);

    assign operand.ready = !queue_full;
    assign push_valid    = operand.valid;

    // decode the operation, negate is rewritten as 0 - a
    always_comb
    begin
        push_item.sub = 1'b0;
        push_item.ar  = operand.a_real;
        push_item.ai  = operand.a_imag;
        push_item.br  = operand.b_real;
        push_item.bi  = operand.b_imag;
        case (operand.operation)
            OP_ADD: push_item.kind = KIND_LIN;
            OP_SUB:
            begin
                push_item.kind = KIND_LIN;
                push_item.sub  = 1'b1;
            end
            OP_MUL: push_item.kind = KIND_MUL;
            OP_DIV: push_item.kind = KIND_DIV;
            OP_NEG:
            begin
                push_item.kind = KIND_LIN;
                push_item.sub  = 1'b1;
                push_item.ar   = '0;
                push_item.ai   = '0;
                push_item.br   = operand.a_real;
                push_item.bi   = operand.a_imag;
            end
            default: push_item.kind = KIND_NONE;
        endcase
    end

endmodule

// ===== rtl/cna_queue.sv =====
// small queue between front and back end
module cna_queue
    import cna_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    input  cna_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      pop_valid,
    output cna_item_t pop_item
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULLC = CW'(DEPTH);

    cna_item_t     mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full      = (count_reg == FULLC);
    assign pop_valid = (count_reg != '0);
    assign pop_item  = mem[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop && pop_valid;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)  rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop) count_next = count_reg + 1'b1;
        else if (do_pop && !do_push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push) mem[wr_ptr_reg] <= push_item;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULLC) else $error("queue count above depth");
    a_full_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        full && !do_pop |=> full) else $error("queue lost an entry while full");
    a_empty_stays: assert property (@(posedge clk) disable iff (!rst_n)
        !pop_valid && !push_valid |=> !pop_valid) else $error("queue filled without push");
`endif

endmodule

// ===== rtl/cna_back.sv =====
// back end: multiply, sum, pipelined divider and output register
module cna_back
    import cna_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    input  cna_item_t q_item,
    output logic      q_pop,
    cna_out_if.source result
);

    logic en;

    // stage 1: products and linear results
    logic               v1_reg;
    kind_t              k1_reg;
    logic signed [63:0] prr_reg, pii_reg, pri_reg, pir_reg;
    logic [63:0]        pbr_reg, pbi_reg;
    logic [31:0]        rr1_reg, ri1_reg;
    logic               ov1_reg;
    logic signed [32:0] lin_re, lin_im;
    logic [32:0]        sat_lr, sat_li;
    logic signed [63:0] pbr_s, pbi_s;

    // stage 2: numerators and divisor
    logic               v2_reg;
    kind_t              k2_reg;
    logic signed [64:0] nre_reg, nim_reg, nre_next, nim_next;
    logic [63:0]        d2_reg;
    logic [31:0]        rr2_reg, ri2_reg;
    logic               ov2_reg;

    // stage 3: sign and magnitude
    logic               v3_reg;
    kind_t              k3_reg;
    logic               sre_reg, sim_reg;
    logic [63:0]        mre_reg, mim_reg;
    logic [64:0]        are_next, aim_next;
    logic [63:0]        d3_reg;
    logic [31:0]        rr3_reg, ri3_reg;
    logic               ov3_reg;

    // stage 4 and divider stages
    logic                          v4_reg;
    div_ctl_t                      c4_reg, c4_next;
    div_part_t                     pre4_reg, pim4_reg, pre4_next, pim4_next;
    logic [DIV_STAGES-1:0]         vd_reg;
    div_ctl_t                      cd_reg  [DIV_STAGES];
    div_part_t                     pred_reg [DIV_STAGES];
    div_part_t                     pimd_reg [DIV_STAGES];
    logic [32:0]                   sat_mr, sat_mi;

    // output register
    logic        vf_reg;
    logic [31:0] rf_reg, if_reg, rf_next, if_next;
    logic [1:0]  sf_reg, sf_next;
    logic [32:0] sat_qr, sat_qi;

    // whole pipe advances unless a result waits on a stalled receiver
    assign en    = !vf_reg || result.ready;
    assign q_pop = en;

    assign result.valid       = vf_reg;
    assign result.result_real = rf_reg;
    assign result.result_imag = if_reg;
    assign result.status      = sf_reg;

    // linear ops and divisor products
    always_comb
    begin
        if (q_item.sub)
        begin
            lin_re = 33'($signed(q_item.ar)) - 33'($signed(q_item.br));
            lin_im = 33'($signed(q_item.ai)) - 33'($signed(q_item.bi));
        end
        else
        begin
            lin_re = 33'($signed(q_item.ar)) + 33'($signed(q_item.br));
            lin_im = 33'($signed(q_item.ai)) + 33'($signed(q_item.bi));
        end
        sat_lr = sat32(lin_re[32], lin_re[32] ? 64'(-lin_re) : 64'(lin_re));
        sat_li = sat32(lin_im[32], lin_im[32] ? 64'(-lin_im) : 64'(lin_im));
        pbr_s  = $signed(q_item.br) * $signed(q_item.br);
        pbi_s  = $signed(q_item.bi) * $signed(q_item.bi);
    end

    // numerators by operation
    always_comb
    begin
        if (k1_reg == KIND_DIV)
        begin
            nre_next = 65'(prr_reg) + 65'(pii_reg);
            nim_next = 65'(pir_reg) - 65'(pri_reg);
        end
        else
        begin
            nre_next = 65'(prr_reg) - 65'(pii_reg);
            nim_next = 65'(pri_reg) + 65'(pir_reg);
        end
        are_next = nre_reg[64] ? -nre_reg : nre_reg;
        aim_next = nim_reg[64] ? -nim_reg : nim_reg;
    end

    // finish non-divide ops, set up the divider
    always_comb
    begin
        sat_mr          = sat32(sre_reg, {16'd0, mre_reg[63:16]});
        sat_mi          = sat32(sim_reg, {16'd0, mim_reg[63:16]});
        c4_next.kind    = k3_reg;
        c4_next.d       = d3_reg;
        c4_next.neg_re  = sre_reg;
        c4_next.neg_im  = sim_reg;
        c4_next.ovf_re  = ({16'd0, mre_reg[63:16]} >= d3_reg);
        c4_next.ovf_im  = ({16'd0, mim_reg[63:16]} >= d3_reg);
        pre4_next.rem   = {16'd0, mre_reg[63:16]};
        pre4_next.qs    = {mre_reg[15:0], 16'd0};
        pim4_next.rem   = {16'd0, mim_reg[63:16]};
        pim4_next.qs    = {mim_reg[15:0], 16'd0};
        case (k3_reg)
            KIND_LIN:
            begin
                c4_next.rr = rr3_reg;
                c4_next.ri = ri3_reg;
                c4_next.st = ov3_reg ? ST_OVF : ST_OK;
            end
            KIND_MUL:
            begin
                c4_next.rr = sat_mr[31:0];
                c4_next.ri = sat_mi[31:0];
                c4_next.st = (sat_mr[32] || sat_mi[32]) ? ST_OVF : ST_OK;
            end
            default:
            begin
                c4_next.rr = '0;
                c4_next.ri = '0;
                c4_next.st = ST_OK;
            end
        endcase
    end

    // final result from the last divider stage
    always_comb
    begin
        sat_qr = sat32(cd_reg[DIV_STAGES-1].neg_re,
                       cd_reg[DIV_STAGES-1].ovf_re ? 64'h1_0000_0000
                                                   : {32'd0, pred_reg[DIV_STAGES-1].qs});
        sat_qi = sat32(cd_reg[DIV_STAGES-1].neg_im,
                       cd_reg[DIV_STAGES-1].ovf_im ? 64'h1_0000_0000
                                                   : {32'd0, pimd_reg[DIV_STAGES-1].qs});
        if (cd_reg[DIV_STAGES-1].kind == KIND_DIV)
        begin
            if (cd_reg[DIV_STAGES-1].d == '0)
            begin
                rf_next = '0;
                if_next = '0;
                sf_next = ST_DZ;
            end
            else
            begin
                rf_next = sat_qr[31:0];
                if_next = sat_qi[31:0];
                sf_next = (sat_qr[32] || sat_qi[32]) ? ST_OVF : ST_OK;
            end
        end
        else
        begin
            rf_next = cd_reg[DIV_STAGES-1].rr;
            if_next = cd_reg[DIV_STAGES-1].ri;
            sf_next = cd_reg[DIV_STAGES-1].st;
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vd_reg <= '0;
            vf_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= q_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            vd_reg <= {vd_reg[DIV_STAGES-2:0], v4_reg};
            vf_reg <= vd_reg[DIV_STAGES-1];
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k1_reg  <= q_item.kind;
            prr_reg <= $signed(q_item.ar) * $signed(q_item.br);
            pii_reg <= $signed(q_item.ai) * $signed(q_item.bi);
            pri_reg <= $signed(q_item.ar) * $signed(q_item.bi);
            pir_reg <= $signed(q_item.ai) * $signed(q_item.br);
            pbr_reg <= pbr_s;
            pbi_reg <= pbi_s;
            rr1_reg <= sat_lr[31:0];
            ri1_reg <= sat_li[31:0];
            ov1_reg <= sat_lr[32] || sat_li[32];

            k2_reg  <= k1_reg;
            nre_reg <= nre_next;
            nim_reg <= nim_next;
            d2_reg  <= pbr_reg + pbi_reg;
            rr2_reg <= rr1_reg;
            ri2_reg <= ri1_reg;
            ov2_reg <= ov1_reg;

            k3_reg  <= k2_reg;
            sre_reg <= nre_reg[64];
            sim_reg <= nim_reg[64];
            mre_reg <= are_next[63:0];
            mim_reg <= aim_next[63:0];
            d3_reg  <= d2_reg;
            rr3_reg <= rr2_reg;
            ri3_reg <= ri2_reg;
            ov3_reg <= ov2_reg;

            c4_reg   <= c4_next;
            pre4_reg <= pre4_next;
            pim4_reg <= pim4_next;

            cd_reg[0]   <= c4_reg;
            pred_reg[0] <= div_step(pre4_reg, c4_reg.d);
            pimd_reg[0] <= div_step(pim4_reg, c4_reg.d);
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                cd_reg[k]   <= cd_reg[k-1];
                pred_reg[k] <= div_step(pred_reg[k-1], cd_reg[k-1].d);
                pimd_reg[k] <= div_step(pimd_reg[k-1], cd_reg[k-1].d);
            end

            rf_reg <= rf_next;
            if_reg <= if_next;
            sf_reg <= sf_next;
        end
    end

`ifndef SYNTHESIS
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status == ST_DZ |->
        result.result_real == '0 && result.result_imag == '0)
        else $error("divide by zero result not zero");
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.status != 2'd3) else $error("bad status code");
    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status == ST_OVF |->
        result.result_real == Q_MAX || result.result_real == Q_MIN ||
        result.result_imag == Q_MAX || result.result_imag == Q_MIN)
        else $error("overflow status without saturated part");
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vd_reg)) else $error("divider moved during stall");
`endif

endmodule

// ===== rtl/complex_number_alu.sv =====
// top level of the complex arithmetic unit
//
// Complex add, subtract, multiply, divide and negate on signed q16.16 values.
// operand channel: valid/ready with operation, a_real, a_imag, b_real,
//   b_imag; a transfer happens when valid and ready are both high.
// result channel: valid/ready with result_real, result_imag, status
//   (ok, overflow saturated, divide by zero magnitude).
// Throughput is one operation per cycle for any mix of operations, as long
//   as the receiver does not stall the result channel. From operand
//   transfer to result valid an operation passes the queue storage, a
//   register stage each for products (taken straight from the queue head),
//   sums, magnitudes and divider setup, 32 restoring divider stages (one
//   quotient bit each), and the output register. Every operation takes the
//   divider path length. When the receiver stalls the whole back pipeline
//   holds; the queue keeps taking operands until it is full, then operand
//   ready drops. Reset clears the queue and all pipeline valid bits; no
//   result is pending after reset and ready rises right away.
module complex_number_alu
    import cna_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    cna_in_if.sink    operand,
    cna_out_if.source result
);

    logic      queue_full;
    logic      push_valid;
    cna_item_t push_item;
    logic      pop;
    logic      pop_valid;
    cna_item_t pop_item;

    // classify incoming transfers
    cna_front u_front (
        .operand    (operand),
        .queue_full (queue_full),
        .push_valid (push_valid),
        .push_item  (push_item)
    );

    // decouple front and back
    cna_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item)
    );

    // arithmetic pipeline
    cna_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (pop_valid),
        .q_item  (pop_item),
        .q_pop   (pop),
        .result  (result)
    );

endmodule

// ===== test/tb_complex_number_alu.sv =====
// self-checking testbench of the complex arithmetic unit
module tb_complex_number_alu;
    import cna_pkg::*;

    logic clk;
    logic rst_n;

    cna_in_if  operand();
    cna_out_if result();

    complex_number_alu dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .operand (operand.sink),
        .result  (result.source)
    );

    // expected result of one operation
    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
        logic [1:0]  st;
    } cplx_res_t;

    // one directed row: operands plus optional typed-in expectation
    typedef struct {
        logic [2:0]  op;
        logic [31:0] ar;
        logic [31:0] ai;
        logic [31:0] br;
        logic [31:0] bi;
        bit          fixed;
        logic [31:0] er;
        logic [31:0] ei;
        logic [1:0]  es;
    } stim_row_t;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_CYCLES = 60;

    cplx_res_t   pending_results[$];
    int unsigned mismatch_count;
    int unsigned cycle_count;
    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;
    bit          timed_out;

    // saturate sign plus magnitude to q16.16
    function automatic logic [31:0] clamp_q(input bit neg, input logic [127:0] mag,
                                            inout bit ovf);
        if (!neg) begin
            if (mag > 128'h7FFF_FFFF)
            begin
                ovf = 1'b1;
                return Q_MAX;
            end
            return mag[31:0];
        end
        if (mag > 128'h8000_0000)
        begin
            ovf = 1'b1;
            return Q_MIN;
        end
        return (~mag[31:0]) + 32'd1;
    endfunction

    // signed value of a q16.16 raw word, widened
    function automatic logic signed [127:0] wide(input logic [31:0] v);
        return {{96{v[31]}}, v};
    endfunction

    // saturate a wide signed value
    function automatic logic [31:0] clamp_s(input logic signed [127:0] v, inout bit ovf);
        if (v < 0)
            return clamp_q(1'b1, -v, ovf);
        return clamp_q(1'b0, v, ovf);
    endfunction

    // truncating q16.16 quotient of wide numerator over denominator
    function automatic logic [31:0] quot_q(input logic signed [127:0] n,
                                           input logic [127:0] d, inout bit ovf);
        logic [127:0] mag;
        logic [127:0] q;
        bit           neg;
        neg = n < 0;
        mag = neg ? -n : n;
        q   = (mag << 16) / d;
        return clamp_q(neg && q != 0, q, ovf);
    endfunction

    // compute the expected complex result
    function automatic cplx_res_t complex_result(input logic [2:0] op,
                                                 input logic [31:0] ar, input logic [31:0] ai,
                                                 input logic [31:0] br, input logic [31:0] bi);
        cplx_res_t              r;
        bit                     ovf;
        logic signed [127:0]    xr;
        logic signed [127:0]    xi;
        logic [127:0]           d;
        ovf = 1'b0;
        r.re = '0;
        r.im = '0;
        r.st = ST_OK;
        case (op)
            OP_ADD:
            begin
                r.re = clamp_s(wide(ar) + wide(br), ovf);
                r.im = clamp_s(wide(ai) + wide(bi), ovf);
            end
            OP_SUB:
            begin
                r.re = clamp_s(wide(ar) - wide(br), ovf);
                r.im = clamp_s(wide(ai) - wide(bi), ovf);
            end
            OP_MUL:
            begin
                xr = wide(ar) * wide(br) - wide(ai) * wide(bi);
                xi = wide(ar) * wide(bi) + wide(ai) * wide(br);
                // truncate toward zero
                xr = (xr < 0) ? -((-xr) >>> 16) : (xr >>> 16);
                xi = (xi < 0) ? -((-xi) >>> 16) : (xi >>> 16);
                r.re = clamp_s(xr, ovf);
                r.im = clamp_s(xi, ovf);
            end
            OP_DIV:
            begin
                d = wide(br) * wide(br) + wide(bi) * wide(bi);
                if (d == 0)
                    r.st = ST_DZ;
                else
                begin
                    xr = wide(ar) * wide(br) + wide(ai) * wide(bi);
                    xi = wide(ai) * wide(br) - wide(ar) * wide(bi);
                    r.re = quot_q(xr, d, ovf);
                    r.im = quot_q(xi, d, ovf);
                end
            end
            OP_NEG:
            begin
                r.re = clamp_s(-wide(ar), ovf);
                r.im = clamp_s(-wide(ai), ovf);
            end
            default: ;
        endcase
        if (r.st == ST_OK && ovf)
            r.st = ST_OVF;
        return r;
    endfunction

    // directed table
    stim_row_t directed_rows[] = '{
        '{OP_ADD, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000,
          1, 32'h0004_0000, 32'h0006_0000, ST_OK},
        '{OP_ADD, Q_MAX, Q_MIN, 32'h1, 32'hFFFF_FFFF, 1, Q_MAX, Q_MIN, ST_OVF},
        '{OP_SUB, Q_MIN, Q_MAX, 32'h1, 32'hFFFF_FFFF, 1, Q_MIN, Q_MAX, ST_OVF},
        '{OP_SUB, 32'h5, 32'h5, 32'h5, 32'h5, 1, 32'h0, 32'h0, ST_OK},
        '{OP_NEG, Q_MIN, Q_MIN, 32'h0, 32'h0, 1, Q_MAX, Q_MAX, ST_OVF},
        '{OP_NEG, Q_MAX, 32'h0, Q_MIN, Q_MAX, 1, 32'h8000_0001, 32'h0, ST_OK},
        '{OP_DIV, 32'h0001_0000, Q_MIN, 32'h0, 32'h0, 1, 32'h0, 32'h0, ST_DZ},
        '{OP_DIV, 32'h0, 32'h0, 32'h0, 32'h0, 1, 32'h0, 32'h0, ST_DZ},
        '{3'd5, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1, 32'h0, 32'h0, ST_OK},
        '{3'd6, Q_MIN, 32'h1, 32'h1, 32'h1, 1, 32'h0, 32'h0, ST_OK},
        '{3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          1, 32'h0, 32'h0, ST_OK},
        '{OP_MUL, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0, 1, 32'h0001_0000, 32'h0, ST_OK},
        '{OP_MUL, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, 0},
        '{OP_MUL, Q_MAX, Q_MAX, Q_MAX, Q_MIN, 0, 0, 0, 0},
        '{OP_MUL, 32'hFFFF_FFFF, 32'h1, 32'h1, 32'hFFFF_FFFF, 0, 0, 0, 0},
        '{OP_MUL, 32'hFFFF_8000, 32'h0000_8000, 32'h0000_8000, 32'h0, 0, 0, 0, 0},
        '{OP_DIV, 32'h0002_0000, 32'h0, 32'h0001_0000, 32'h0, 1, 32'h0002_0000, 32'h0, ST_OK},
        '{OP_DIV, Q_MAX, Q_MIN, 32'h1, 32'h0, 0, 0, 0, 0},
        '{OP_DIV, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, 0},
        '{OP_DIV, 32'h1, 32'hFFFF_FFFF, Q_MAX, Q_MAX, 0, 0, 0, 0},
        '{OP_DIV, 32'hFFFF_0000, 32'h0003_0000, 32'h0, 32'hFFFF_FFFF, 0, 0, 0, 0},
        '{OP_DIV, 32'h0001_0000, 32'h0, 32'h0003_0000, 32'h0, 0, 0, 0, 0}
    };

    // random operand word with a bias to edges and small values
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return 32'h0;
            3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
            4, 5: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
            6: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // cycle counter and timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("tb: failure");
            $finish;
        end
    end

    // result receiver: random stalls and checking
    always @(posedge clk)
    begin
        cplx_res_t exp_r;
        if (rst_n)
        begin
            if (result.valid && result.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("unexpected transfer: %h %h %0d", result.result_real,
                                 result.result_imag, result.status);
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (result.result_real !== exp_r.re || result.result_imag !== exp_r.im
                        || result.status !== exp_r.st)
                    begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= 10)
                            $display("mismatch: exp %h %h %0d got %h %h %0d", exp_r.re,
                                     exp_r.im, exp_r.st, result.result_real,
                                     result.result_imag, result.status);
                    end
                end
            end
            result.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // send one operation and record its expectation
    task automatic send_op(input logic [2:0] op, input logic [31:0] ar, input logic [31:0] ai,
                           input logic [31:0] br, input logic [31:0] bi, input cplx_res_t r);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            operand.valid <= 1'b0;
            @(posedge clk);
        end
        operand.valid     <= 1'b1;
        operand.operation <= op;
        operand.a_real    <= ar;
        operand.a_imag    <= ai;
        operand.b_real    <= br;
        operand.b_imag    <= bi;
        @(posedge clk);
        while (!operand.ready)
            @(posedge clk);
        pending_results.push_back(r);
    endtask

    // stimulus
    initial
    begin
        cplx_res_t   r;
        logic [2:0]  op;
        logic [31:0] ar;
        logic [31:0] ai;
        logic [31:0] br;
        logic [31:0] bi;
        int unsigned wait_n;
        mismatch_count    = 0;
        cycle_count       = 0;
        timed_out         = 1'b0;
        src_idle_pct      = 6;
        snk_idle_pct      = 46;
        rst_n             = 1'b0;
        operand.valid     = 1'b0;
        operand.operation = '0;
        operand.a_real    = '0;
        operand.a_imag    = '0;
        operand.b_real    = '0;
        operand.b_imag    = '0;
        result.ready      = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].fixed)
            begin
                r.re = directed_rows[i].er;
                r.im = directed_rows[i].ei;
                r.st = directed_rows[i].es;
            end
            else
                r = complex_result(directed_rows[i].op, directed_rows[i].ar,
                                   directed_rows[i].ai, directed_rows[i].br,
                                   directed_rows[i].bi);
            send_op(directed_rows[i].op, directed_rows[i].ar, directed_rows[i].ai,
                    directed_rows[i].br, directed_rows[i].bi, r);
        end

        // random items in three idling phases
        for (int n = 0; n < 1450; n++)
        begin
            if (n == 480)
            begin
                src_idle_pct = 46;
                snk_idle_pct = 6;
            end
            else if (n == 960)
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
            ar = pick_word();
            ai = pick_word();
            br = pick_word();
            bi = pick_word();
            if (op == OP_DIV && $urandom_range(0, 29) == 0)
            begin
                br = '0;
                bi = '0;
            end
            send_op(op, ar, ai, br, bi, complex_result(op, ar, ai, br, bi));
        end
        operand.valid <= 1'b0;

        // drain
        wait_n = 0;
        while (pending_results.size() != 0 && wait_n < 100000)
        begin
            @(posedge clk);
            wait_n++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/cna_pkg.sv
rtl/cna_in_if.sv
rtl/cna_out_if.sv
rtl/cna_front.sv
rtl/cna_queue.sv
rtl/cna_back.sv
rtl/complex_number_alu.sv
test/tb_complex_number_alu.sv
